// ----- rtl/core/rgb_pair_to_ycbcr422_assert.svh -----
// Assertion macros used by the checker file of this block, ryc_check.
`ifndef RGB_PAIR_TO_YCBCR422_ASSERT_SVH
`define RGB_PAIR_TO_YCBCR422_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RYC_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("rgb_pair_to_ycbcr422 check failed");

// Next-cycle implication, disabled while reset is held.
`define RYC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("rgb_pair_to_ycbcr422 check failed");

// Next-cycle implication that also runs through reset.
`define RYC_ASSERT_RST_NEXT(lbl, clk_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("rgb_pair_to_ycbcr422 reset check failed");

`endif

// ----- rtl/core/ryc_pkg.sv -----
package ryc_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned LUMA_W   = 18;  // holds 299R + 587G + 114B
  localparam int unsigned CHROMA_W = 25;  // holds the offset chroma numerators

  localparam int unsigned LUMA_DIV   = 1000;
  localparam int unsigned CHROMA_DIV = 100000;

  typedef logic [PIX_W-1:0]    ryc_pix_t;
  typedef logic [PIX_W:0]      ryc_pix_sum_t;
  typedef logic [LUMA_W-1:0]   ryc_luma_t;
  typedef logic [CHROMA_W-1:0] ryc_chroma_t;

  localparam ryc_luma_t Y_C_R = 18'd299;
  localparam ryc_luma_t Y_C_G = 18'd587;
  localparam ryc_luma_t Y_C_B = 18'd114;

  localparam ryc_chroma_t CB_C_R   = 25'd16874;   // subtracted
  localparam ryc_chroma_t CB_C_G   = 25'd33126;   // subtracted
  localparam ryc_chroma_t CB_C_B   = 25'd50000;
  localparam ryc_chroma_t CR_C_R   = 25'd50000;
  localparam ryc_chroma_t CR_C_G   = 25'd41869;   // subtracted
  localparam ryc_chroma_t CR_C_B   = 25'd8131;    // subtracted
  localparam ryc_chroma_t C_OFFSET = 25'd12800000;

  typedef struct packed {
    ryc_pix_t red_first;
    ryc_pix_t green_first;
    ryc_pix_t blue_first;
    ryc_pix_t red_second;
    ryc_pix_t green_second;
    ryc_pix_t blue_second;
  } ryc_rgb_pair_t;

  typedef struct packed {
    ryc_pix_t luma_first;
    ryc_pix_t chroma_blue;
    ryc_pix_t luma_second;
    ryc_pix_t chroma_red;
  } ryc_ycc_t;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic prod;
    logic sum;
    logic est;
    logic fix;
    logic out;
  } ryc_stage_en_t;

endpackage

// ----- rtl/core/ryc_stream_if.sv -----
interface ryc_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/ryc_ctrl.sv -----
module ryc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  out_ready,
  output logic                  in_ready,
  output logic                  out_valid,
  output ryc_pkg::ryc_stage_en_t en
);

  logic v_prod_r, v_sum_r, v_est_r, v_fix_r, v_out_r;

  // A stage loads when it is empty or when the stage after it loads too.
  always_comb begin
    en.out  = !v_out_r  || out_ready;
    en.fix  = !v_fix_r  || en.out;
    en.est  = !v_est_r  || en.fix;
    en.sum  = !v_sum_r  || en.est;
    en.prod = !v_prod_r || en.sum;
  end

  assign in_ready  = en.prod;
  assign out_valid = v_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_prod_r <= 1'b0;
      v_sum_r  <= 1'b0;
      v_est_r  <= 1'b0;
      v_fix_r  <= 1'b0;
      v_out_r  <= 1'b0;
    end else begin
      if (en.prod) v_prod_r <= in_valid;
      if (en.sum)  v_sum_r  <= v_prod_r;
      if (en.est)  v_est_r  <= v_sum_r;
      if (en.fix)  v_fix_r  <= v_est_r;
      if (en.out)  v_out_r  <= v_fix_r;
    end
  end

endmodule

// ----- rtl/core/ryc_mac.sv -----
module ryc_mac (
  input  logic                  clk,
  input  ryc_pkg::ryc_stage_en_t en,
  input  ryc_pkg::ryc_pix_t     red,
  input  ryc_pkg::ryc_pix_t     green,
  input  ryc_pkg::ryc_pix_t     blue,
  output ryc_pkg::ryc_luma_t    luma_num,
  output ryc_pkg::ryc_chroma_t  cb_num,
  output ryc_pkg::ryc_chroma_t  cr_num
);

  ryc_pkg::ryc_luma_t   y_r_r, y_g_r, y_b_r;
  ryc_pkg::ryc_chroma_t cb_r_r, cb_g_r, cb_b_r;
  ryc_pkg::ryc_chroma_t cr_r_r, cr_g_r, cr_b_r;
  ryc_pkg::ryc_luma_t   luma_num_r;
  ryc_pkg::ryc_chroma_t cb_num_r, cr_num_r;

  always_ff @(posedge clk) begin
    if (en.prod) begin
      y_r_r  <= ryc_pkg::ryc_luma_t'(red)     * ryc_pkg::Y_C_R;
      y_g_r  <= ryc_pkg::ryc_luma_t'(green)   * ryc_pkg::Y_C_G;
      y_b_r  <= ryc_pkg::ryc_luma_t'(blue)    * ryc_pkg::Y_C_B;
      cb_r_r <= ryc_pkg::ryc_chroma_t'(red)   * ryc_pkg::CB_C_R;
      cb_g_r <= ryc_pkg::ryc_chroma_t'(green) * ryc_pkg::CB_C_G;
      cb_b_r <= ryc_pkg::ryc_chroma_t'(blue)  * ryc_pkg::CB_C_B;
      cr_r_r <= ryc_pkg::ryc_chroma_t'(red)   * ryc_pkg::CR_C_R;
      cr_g_r <= ryc_pkg::ryc_chroma_t'(green) * ryc_pkg::CR_C_G;
      cr_b_r <= ryc_pkg::ryc_chroma_t'(blue)  * ryc_pkg::CR_C_B;
    end
  end

  // The true chroma sums never leave 50000..25550000, so modular
  // arithmetic at this width gives the exact value.
  always_ff @(posedge clk) begin
    if (en.sum) begin
      luma_num_r <= y_r_r + y_g_r + y_b_r;
      cb_num_r   <= cb_b_r + ryc_pkg::C_OFFSET - cb_r_r - cb_g_r;
      cr_num_r   <= cr_r_r + ryc_pkg::C_OFFSET - cr_g_r - cr_b_r;
    end
  end

  assign luma_num = luma_num_r;
  assign cb_num   = cb_num_r;
  assign cr_num   = cr_num_r;

endmodule

// ----- rtl/core/ryc_cdiv.sv -----
// Truncating division by a constant: reciprocal multiply, then one
// compare-and-add correction, since the estimate is low by at most one.
module ryc_cdiv #(
  parameter int unsigned N_W = 18,
  parameter int unsigned DIV = 1000
) (
  input  logic                  clk,
  input  ryc_pkg::ryc_stage_en_t en,
  input  logic [N_W-1:0]        num,
  output ryc_pkg::ryc_pix_t     quo
);

  localparam int unsigned RECIP = (2 ** N_W) / DIV;
  localparam int unsigned R_W   = $clog2(RECIP + 1);
  localparam int unsigned P_W   = N_W + R_W;
  localparam int unsigned Q_W   = ryc_pkg::PIX_W;

  logic [P_W-1:0] prod;
  logic [Q_W-1:0] q_est_r;
  logic [N_W-1:0] num_r;
  logic [N_W-1:0] rem;
  logic [Q_W-1:0] quo_r;

  assign prod = P_W'(num) * P_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en.est) begin
      q_est_r <= prod[N_W +: Q_W];
      num_r   <= num;
    end
  end

  assign rem = num_r - N_W'(q_est_r) * N_W'(DIV);

  always_ff @(posedge clk) begin
    if (en.fix) begin
      quo_r <= q_est_r + Q_W'(rem >= N_W'(DIV));
    end
  end

  assign quo = quo_r;

endmodule

// ----- rtl/core/rgb_pair_to_ycbcr422.sv -----
// Throughput: one pixel pair per clock while out_ch.ready is high; the five-stage pipeline is
// multiply, sum, reciprocal estimate, correction, chroma average/output.
// Ready runs back from stage to stage, so an empty stage keeps accepting during a stall.
// Reset (rst_n low, synchronous) clears only the stage valid bits; data is not reset.
module rgb_pair_to_ycbcr422 (
  input  logic          clk,
  input  logic          rst_n,
  ryc_stream_if.sink    in_ch,
  ryc_stream_if.source  out_ch
);

  // Stage control: one valid bit per stage and a load enable for each one.
  // The enables are shared by every datapath register of the same stage, so
  // payload and valid bits move together and a stall holds both in place.
  ryc_pkg::ryc_stage_en_t en;
  logic                   out_valid;

  ryc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .out_valid (out_valid),
    .en        (en)
  );

  ryc_pkg::ryc_rgb_pair_t pix;
  assign pix = in_ch.data;

  // Stages one and two: per-pixel coefficient products, then the luma and
  // offset chroma numerators.
  ryc_pkg::ryc_luma_t   y1_num, y2_num;
  ryc_pkg::ryc_chroma_t cb1_num, cb2_num, cr1_num, cr2_num;

  ryc_mac u_mac_first (
    .clk      (clk),
    .en       (en),
    .red      (pix.red_first),
    .green    (pix.green_first),
    .blue     (pix.blue_first),
    .luma_num (y1_num),
    .cb_num   (cb1_num),
    .cr_num   (cr1_num)
  );

  ryc_mac u_mac_second (
    .clk      (clk),
    .en       (en),
    .red      (pix.red_second),
    .green    (pix.green_second),
    .blue     (pix.blue_second),
    .luma_num (y2_num),
    .cb_num   (cb2_num),
    .cr_num   (cr2_num)
  );

  // Stages three and four: luma is divided by 1000 and each chroma value by
  // 100000. The numerators are never negative, so truncation is a floor.
  ryc_pkg::ryc_pix_t y1, y2, cb1, cb2, cr1, cr2;

  ryc_cdiv #(.N_W(ryc_pkg::LUMA_W), .DIV(ryc_pkg::LUMA_DIV)) u_div_y1 (
    .clk (clk), .en (en), .num (y1_num), .quo (y1)
  );
  ryc_cdiv #(.N_W(ryc_pkg::LUMA_W), .DIV(ryc_pkg::LUMA_DIV)) u_div_y2 (
    .clk (clk), .en (en), .num (y2_num), .quo (y2)
  );
  ryc_cdiv #(.N_W(ryc_pkg::CHROMA_W), .DIV(ryc_pkg::CHROMA_DIV)) u_div_cb1 (
    .clk (clk), .en (en), .num (cb1_num), .quo (cb1)
  );
  ryc_cdiv #(.N_W(ryc_pkg::CHROMA_W), .DIV(ryc_pkg::CHROMA_DIV)) u_div_cb2 (
    .clk (clk), .en (en), .num (cb2_num), .quo (cb2)
  );
  ryc_cdiv #(.N_W(ryc_pkg::CHROMA_W), .DIV(ryc_pkg::CHROMA_DIV)) u_div_cr1 (
    .clk (clk), .en (en), .num (cr1_num), .quo (cr1)
  );
  ryc_cdiv #(.N_W(ryc_pkg::CHROMA_W), .DIV(ryc_pkg::CHROMA_DIV)) u_div_cr2 (
    .clk (clk), .en (en), .num (cr2_num), .quo (cr2)
  );

  // Stage five: the two pixels share one Cb and one Cr, averaged with a
  // floor shift. This register is also the output register of the channel.
  ryc_pkg::ryc_pix_sum_t cb_sum, cr_sum;
  ryc_pkg::ryc_ycc_t     out_data_r;

  assign cb_sum = ryc_pkg::ryc_pix_sum_t'(cb1) + ryc_pkg::ryc_pix_sum_t'(cb2);
  assign cr_sum = ryc_pkg::ryc_pix_sum_t'(cr1) + ryc_pkg::ryc_pix_sum_t'(cr2);

  always_ff @(posedge clk) begin
    if (en.out) begin
      out_data_r.luma_first  <= y1;
      out_data_r.luma_second <= y2;
      out_data_r.chroma_blue <= cb_sum[ryc_pkg::PIX_W:1];
      out_data_r.chroma_red  <= cr_sum[ryc_pkg::PIX_W:1];
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data_r;

endmodule

// ----- rtl/core/ryc_check.sv -----
`include "rgb_pair_to_ycbcr422_assert.svh"

module ryc_check (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ryc_pkg::ryc_ycc_t out_data
);

  // Reset empties the pipeline, so no result may follow a reset cycle.
  `RYC_ASSERT_RST_NEXT(a_reset_empty, clk, !rst_n, !out_valid)

  // A result that is not taken stays offered, with the same payload.
  `RYC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `RYC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))

  // With the sink taking results, the pipeline moves and never refuses a request.
  `RYC_ASSERT_IMPL(a_no_bubble_stall, clk, rst_n, out_ready, in_ready)

endmodule

bind rgb_pair_to_ycbcr422 ryc_check u_ryc_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ----- tb/sv/ycbcr_pair_checker.sv -----
// Watches both streams of the RGB pair to 4:2:2 converter, predicts the packed
// word for every accepted pixel pair and compares it with what comes out.
module ycbcr_pair_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  ryc_pkg::ryc_rgb_pair_t in_pair,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  ryc_pkg::ryc_ycc_t      out_word,
  output int unsigned            mismatch_count,
  output int unsigned            checked_count,
  output int unsigned            outstanding
);

  ryc_pkg::ryc_ycc_t ycc_expected[$];
  int unsigned       errors_seen;
  int unsigned       words_seen;

  function automatic int unsigned pixel_luma(ryc_pkg::ryc_pix_t r, ryc_pkg::ryc_pix_t g,
                                             ryc_pkg::ryc_pix_t b);
    return (32'd299 * r + 32'd587 * g + 32'd114 * b) / 32'd1000;
  endfunction

  // Both chroma numerators stay positive, so plain unsigned math is exact.
  function automatic int unsigned pixel_cb(ryc_pkg::ryc_pix_t r, ryc_pkg::ryc_pix_t g,
                                           ryc_pkg::ryc_pix_t b);
    return (32'd50000 * b + 32'd12800000 - 32'd16874 * r - 32'd33126 * g) / 32'd100000;
  endfunction

  function automatic int unsigned pixel_cr(ryc_pkg::ryc_pix_t r, ryc_pkg::ryc_pix_t g,
                                           ryc_pkg::ryc_pix_t b);
    return (32'd50000 * r + 32'd12800000 - 32'd41869 * g - 32'd8131 * b) / 32'd100000;
  endfunction

  function automatic ryc_pkg::ryc_ycc_t predict_ycc(ryc_pkg::ryc_rgb_pair_t p);
    ryc_pkg::ryc_ycc_t w;
    int unsigned       cb_sum;
    int unsigned       cr_sum;
    cb_sum = pixel_cb(p.red_first, p.green_first, p.blue_first)
           + pixel_cb(p.red_second, p.green_second, p.blue_second);
    cr_sum = pixel_cr(p.red_first, p.green_first, p.blue_first)
           + pixel_cr(p.red_second, p.green_second, p.blue_second);
    w.luma_first  = 8'(pixel_luma(p.red_first, p.green_first, p.blue_first));
    w.luma_second = 8'(pixel_luma(p.red_second, p.green_second, p.blue_second));
    w.chroma_blue = 8'(cb_sum >> 1);
    w.chroma_red  = 8'(cr_sum >> 1);
    return w;
  endfunction

  always @(posedge clk) begin
    string             field_name [4];
    ryc_pkg::ryc_ycc_t want;
    logic [7:0]        want_b;
    logic [7:0]        got_b;
    field_name = '{"luma_first", "chroma_blue", "luma_second", "chroma_red"};
    if (rst_n) begin
      if (in_valid && in_ready) begin
        ycc_expected.push_back(predict_ycc(in_pair));
      end
      if (out_valid && out_ready) begin
        words_seen++;
        if (ycc_expected.size() == 0) begin
          errors_seen++;
          $error("result %h arrived with no pixel pair outstanding", out_word);
        end else begin
          want = ycc_expected.pop_front();
          for (int i = 0; i < 4; i++) begin
            want_b = want[31 - 8 * i -: 8];
            got_b  = out_word[31 - 8 * i -: 8];
            if (want_b !== got_b) begin
              errors_seen++;
              $error("%s mismatch: expected %0d, got %0d", field_name[i], want_b, got_b);
            end
          end
        end
      end
    end
    mismatch_count <= errors_seen;
    checked_count  <= words_seen;
    outstanding    <= ycc_expected.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the converter testbench. It drives pixel-pair requests into the block,
// throttles the result side, and lets the checker beside the block do all of
// the prediction and comparison. This module only makes stimulus and reports.
module testbench;

  logic clk = 1'b0;
  logic rst_n;

  // When set, neither the request side nor the result side inserts bubbles.
  logic calm;

  int unsigned mismatch_count;
  int unsigned checked_count;
  int unsigned outstanding;
  int unsigned pairs_sent;

  ryc_stream_if #(.payload_t(ryc_pkg::ryc_rgb_pair_t)) pix_if ();
  ryc_stream_if #(.payload_t(ryc_pkg::ryc_ycc_t))      ycc_if ();

  rgb_pair_to_ycbcr422 u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_if),
    .out_ch (ycc_if)
  );

  ycbcr_pair_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (pix_if.valid),
    .in_ready       (pix_if.ready),
    .in_pair        (pix_if.data),
    .out_valid      (ycc_if.valid),
    .out_ready      (ycc_if.ready),
    .out_word       (ycc_if.data),
    .mismatch_count (mismatch_count),
    .checked_count  (checked_count),
    .outstanding    (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The result side stalls with a chance of about 37 in 100 unless a calm stretch
  // is running. Ready is redrawn every cycle, so stalls land on every stage of
  // the pipeline, including cycles where the output holds a finished word.
  always @(posedge clk) begin
    ycc_if.ready <= calm || ($urandom_range(99) >= 37);
  end

  // Present one request and hold it until the block takes it. Before the
  // request goes up the sender may sit idle for a few random cycles. Valid is
  // assigned once per time step, so a back-to-back request simply keeps it high.
  task automatic send_pair(input ryc_pkg::ryc_rgb_pair_t p);
    while (!calm && $urandom_range(99) < 37) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.data  <= p;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    pairs_sent++;
  endtask

  // Picks one color component, leaning toward the two rails now and then.
  function automatic ryc_pkg::ryc_pix_t pick_component(input bit rails);
    if (rails && $urandom_range(2) != 0) begin
      return $urandom_range(1) ? 8'hff : 8'h00;
    end
    return 8'($urandom_range(255));
  endfunction

  initial begin
    ryc_pkg::ryc_rgb_pair_t p;
    bit                     rails;

    // Every input of the block is known before the first clock edge.
    rst_n        = 1'b0;
    calm         = 1'b0;
    pairs_sent   = 0;
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    ycc_if.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: black, white, the primaries, and pairs whose two
    // pixels sit at opposite chroma corners so the averaging is exercised at
    // its widest spread and on odd sums.
    send_pair('{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
    send_pair('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    send_pair('{8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0});
    send_pair('{8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0});
    send_pair('{8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255});
    send_pair('{8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255});
    send_pair('{8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0});
    send_pair('{8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0});
    send_pair('{8'd0,   8'd255, 8'd255, 8'd255, 8'd0,   8'd0});
    send_pair('{8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd0});
    send_pair('{8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd255});
    send_pair('{8'd128, 8'd128, 8'd128, 8'd127, 8'd127, 8'd127});
    send_pair('{8'd1,   8'd1,   8'd1,   8'd254, 8'd254, 8'd254});
    send_pair('{8'd170, 8'd85,  8'd170, 8'd85,  8'd170, 8'd85});

    // Random requests. About one in ten draws its components mostly from the
    // rails; a calm stretch in the middle runs both sides at full rate.
    for (int n = 0; n < 1250; n++) begin
      calm  = (n >= 500 && n < 700);
      rails = ($urandom_range(9) == 0);
      p.red_first    = pick_component(rails);
      p.green_first  = pick_component(rails);
      p.blue_first   = pick_component(rails);
      p.red_second   = pick_component(rails);
      p.green_second = pick_component(rails);
      p.blue_second  = pick_component(rails);
      send_pair(p);
    end
    calm = 1'b0;
    pix_if.valid <= 1'b0;

    // Drain: wait until every predicted word has come back, then give the
    // five-stage pipeline some extra cycles to show any stray result.
    do @(posedge clk); while (outstanding != 0);
    repeat (12) @(posedge clk);

    $display("Sent %0d pixel pairs (rails, primaries and random colors) and checked %0d words.",
             pairs_sent, checked_count);
    $display("Both sides ran with random bubbles plus one full-rate stretch.");
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Safety net: far beyond the slowest legal run of about 1300 requests.
  initial begin
    #4000000;
    $display("Timeout: %0d words still outstanding.", outstanding);
    $display("Test completed with failures");
    $finish;
  end

endmodule
